### rtl/core/pat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pat_pkg;

  // Table key is {ip_addr, port_number}
  localparam int unsigned KeyW  = 48;
  localparam int unsigned CodeW = 2;
  localparam int unsigned SlotW = 4;

  // State code reported when a peer is not in the known table
  localparam logic [1:0] NOT_KNOWN = 2'd3;

  // Request codes
  typedef enum logic [1:0] {
    FUNC_FIND_CONN   = 2'd0,
    FUNC_ADD_KNOWN   = 2'd1,
    FUNC_QUERY_KNOWN = 2'd2,
    FUNC_ADD_CONN    = 2'd3
  } func_e;

  // Request beat
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] ip_addr;
    logic [15:0] port_number;
    logic [1:0]  peer_state;
  } in_t;

  // Response beat
  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot_index;
    logic [1:0]       state_out;
    logic             table_full;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic scan_start;
    logic scan_step;
    logic shift_start;
    logic shift_step;
    logic add_known;
    logic add_conn;
    logic known_dec;
    logic res_hit;
    logic res_miss;
    logic res_full;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       known_full;
    logic       conn_full;
    logic       scan_hit;
    logic       walk_done;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/pat_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module pat_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/pat_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Datapath: request registers, both tables, walk counter, result registers
module pat_dp #(
  parameter int unsigned KNOWN_DEPTH     = 16,
  parameter int unsigned CONNECTED_DEPTH = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  pat_pkg::in_t      in_data_i,
  input  pat_pkg::cmd_t     cmd_i,
  output pat_pkg::status_t  status_o,
  output pat_pkg::out_t     out_data_o
);

  localparam int unsigned KIW = $clog2(KNOWN_DEPTH);
  localparam int unsigned CIW = $clog2(CONNECTED_DEPTH);
  localparam int unsigned KCW = $clog2(KNOWN_DEPTH + 1);
  localparam int unsigned CCW = $clog2(CONNECTED_DEPTH + 1);
  localparam int unsigned RW  = (KCW > CCW) ? KCW : CCW;
  localparam int unsigned KWW = pat_pkg::KeyW + pat_pkg::CodeW;

  // Latched request
  logic [1:0]                 func_q;
  logic [pat_pkg::KeyW-1:0]   key_q;
  logic [pat_pkg::CodeW-1:0]  code_q;

  // Table fill counts
  logic [KCW-1:0] known_count_q, known_count_d;
  logic [CCW-1:0] conn_count_q, conn_count_d;

  // Walk pointer and compare stage
  logic [RW-1:0] rd_q, rd_d;
  logic [RW-1:0] cmp_idx_q, cmp_idx_d;
  logic          cmp_v_q, cmp_v_d;

  pat_pkg::out_t res_q, res_d;
  pat_pkg::out_t out_q;

  logic                     is_conn;
  logic [RW-1:0]            lim;
  logic                     rd_lt;
  logic                     step;
  logic [KWW-1:0]           known_rdata;
  logic [pat_pkg::KeyW-1:0] conn_rdata;
  logic [pat_pkg::KeyW-1:0] rd_key;
  logic                     known_we;
  logic [KIW-1:0]           known_waddr;
  logic [KWW-1:0]           known_wdata;
  logic                     known_re;
  logic                     conn_re;
  logic [RW+3:0]            idx_ext;
  logic [KCW+3:0]           kcnt_ext;
  logic [CCW+3:0]           ccnt_ext;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      func_q <= in_data_i.func;
      key_q  <= {in_data_i.ip_addr, in_data_i.port_number};
      code_q <= in_data_i.peer_state;
    end
  end

  assign is_conn = (func_q == pat_pkg::FUNC_FIND_CONN);
  assign lim     = is_conn ? RW'(conn_count_q) : RW'(known_count_q);
  assign rd_lt   = (rd_q < lim);
  assign step    = cmd_i.scan_step | cmd_i.shift_step;

  // Walk pointer: scan issues reads from slot 0, shift from one past the hit
  always_comb begin
    rd_d      = rd_q;
    cmp_v_d   = cmp_v_q;
    cmp_idx_d = cmp_idx_q;
    if (cmd_i.scan_start) begin
      rd_d    = '0;
      cmp_v_d = 1'b0;
    end else if (cmd_i.shift_start) begin
      rd_d    = cmp_idx_q + RW'(1);
      cmp_v_d = 1'b0;
    end else if (step) begin
      if (rd_lt) begin
        rd_d      = rd_q + RW'(1);
        cmp_v_d   = 1'b1;
        cmp_idx_d = cmd_i.shift_step ? (rd_q - RW'(1)) : rd_q;
      end else begin
        cmp_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q      <= '0;
      cmp_v_q   <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      rd_q      <= rd_d;
      cmp_v_q   <= cmp_v_d;
      cmp_idx_q <= cmp_idx_d;
    end
  end

  // Known table: {key, code}
  assign known_re    = step & rd_lt & ~is_conn;
  assign known_we    = cmd_i.add_known | (cmd_i.shift_step & cmp_v_q);
  assign known_waddr = cmd_i.add_known ? known_count_q[KIW-1:0] : cmp_idx_q[KIW-1:0];
  assign known_wdata = cmd_i.add_known ? {key_q, code_q} : known_rdata;

  pat_ram #(
    .Width (KWW),
    .Depth (KNOWN_DEPTH)
  ) u_known_ram (
    .clk_i   (clk_i),
    .we_i    (known_we),
    .waddr_i (known_waddr),
    .wdata_i (known_wdata),
    .re_i    (known_re),
    .raddr_i (rd_q[KIW-1:0]),
    .rdata_o (known_rdata)
  );

  // Connected table: key only
  assign conn_re = cmd_i.scan_step & rd_lt & is_conn;

  pat_ram #(
    .Width (pat_pkg::KeyW),
    .Depth (CONNECTED_DEPTH)
  ) u_conn_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_conn),
    .waddr_i (conn_count_q[CIW-1:0]),
    .wdata_i (key_q),
    .re_i    (conn_re),
    .raddr_i (rd_q[CIW-1:0]),
    .rdata_o (conn_rdata)
  );

  // Fill counts
  always_comb begin
    known_count_d = known_count_q;
    conn_count_d  = conn_count_q;
    if (cmd_i.add_known) begin
      known_count_d = known_count_q + KCW'(1);
    end else if (cmd_i.known_dec) begin
      known_count_d = known_count_q - KCW'(1);
    end
    if (cmd_i.add_conn) begin
      conn_count_d = conn_count_q + CCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_count_q <= '0;
      conn_count_q  <= '0;
    end else begin
      known_count_q <= known_count_d;
      conn_count_q  <= conn_count_d;
    end
  end

  // Key compare on the registered read data
  assign rd_key = is_conn ? conn_rdata : known_rdata[KWW-1:pat_pkg::CodeW];

  assign status_o.func       = func_q;
  assign status_o.known_full = (known_count_q == KCW'(KNOWN_DEPTH));
  assign status_o.conn_full  = (conn_count_q == CCW'(CONNECTED_DEPTH));
  assign status_o.scan_hit   = cmp_v_q & (rd_key == key_q);
  assign status_o.walk_done  = ~rd_lt & ~cmp_v_q;

  // Slot numbers carry only their low four bits
  assign idx_ext  = {4'b0, cmp_idx_q};
  assign kcnt_ext = {4'b0, known_count_q};
  assign ccnt_ext = {4'b0, conn_count_q};

  // Result build
  always_comb begin
    res_d = res_q;
    if (cmd_i.res_hit) begin
      res_d.found      = 1'b1;
      res_d.slot_index = idx_ext[3:0];
      res_d.state_out  = (func_q == pat_pkg::FUNC_QUERY_KNOWN) ?
                         known_rdata[pat_pkg::CodeW-1:0] : pat_pkg::NOT_KNOWN;
      res_d.table_full = 1'b0;
    end else if (cmd_i.res_miss || cmd_i.res_full) begin
      res_d.found      = 1'b0;
      res_d.slot_index = '0;
      res_d.state_out  = pat_pkg::NOT_KNOWN;
      res_d.table_full = cmd_i.res_full;
    end else if (cmd_i.add_known || cmd_i.add_conn) begin
      res_d.found      = 1'b1;
      res_d.slot_index = cmd_i.add_known ? kcnt_ext[3:0] : ccnt_ext[3:0];
      res_d.state_out  = pat_pkg::NOT_KNOWN;
      res_d.table_full = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

### rtl/core/pat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Controller: sequences one request at a time, owns the output valid
module pat_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  pat_pkg::status_t  status_i,
  output pat_pkg::cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DISPATCH = 5'b00010,
    ST_SCAN     = 5'b00100,
    ST_SHIFT    = 5'b01000,
    ST_FIN      = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = ~out_valid_q | out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.func)
          pat_pkg::FUNC_ADD_KNOWN: begin
            if (status_i.known_full) begin
              cmd_o.res_full = 1'b1;
            end else begin
              cmd_o.add_known = 1'b1;
            end
            state_d = ST_FIN;
          end
          pat_pkg::FUNC_ADD_CONN: begin
            if (status_i.conn_full) begin
              cmd_o.res_full = 1'b1;
              state_d        = ST_FIN;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          default: begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        endcase
      end
      ST_SCAN: begin
        if (status_i.scan_hit) begin
          if (status_i.func == pat_pkg::FUNC_ADD_CONN) begin
            cmd_o.shift_start = 1'b1;
            state_d           = ST_SHIFT;
          end else begin
            cmd_o.res_hit = 1'b1;
            state_d       = ST_FIN;
          end
        end else if (status_i.walk_done) begin
          if (status_i.func == pat_pkg::FUNC_ADD_CONN) begin
            cmd_o.add_conn = 1'b1;
          end else begin
            cmd_o.res_miss = 1'b1;
          end
          state_d = ST_FIN;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (status_i.walk_done) begin
          cmd_o.known_dec = 1'b1;
          cmd_o.add_conn  = 1'b1;
          state_d         = ST_FIN;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/peer_address_tables.sv
// Result valid follows the walk for each request: add known needs no walk; find
// connected and query known scan their table up to a hit or the end; add connected
// scans the known table and, on a hit, shifts the later entries down one slot.
// Throughput: one request in flight, the next accepted in the cycle after its result
// loads; the one-entry-per-cycle walk of a registered-read RAM sets the time.
// Reset: asynchronous, active low; both fill counts clear, table data is kept.
`timescale 1ns / 1ps
`default_nettype none

module peer_address_tables #(
  parameter int unsigned KNOWN_DEPTH     = 16,
  parameter int unsigned CONNECTED_DEPTH = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  pat_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output pat_pkg::out_t  out_data_o
);

  pat_pkg::cmd_t    cmd;
  pat_pkg::status_t status;

  pat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pat_dp #(
    .KNOWN_DEPTH     (KNOWN_DEPTH),
    .CONNECTED_DEPTH (CONNECTED_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/core/pat_chk.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the peer tables
module pat_chk (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_ready_o,
  input pat_pkg::in_t   in_data_i,
  input wire            out_valid_o,
  input wire            out_ready_i,
  input pat_pkg::out_t  out_data_o
);

  // One request at a time: no second beat right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted back to back");

  // A refused append never reports a hit
  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.table_full |-> !out_data_o.found)
    else $error("table_full with found set");

  // No hit means slot zero
  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.slot_index == 4'd0)
    else $error("nonzero slot without a hit");

  // A real state code only comes with a hit
  a_state_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.state_out == pat_pkg::NOT_KNOWN)
    else $error("state code without a hit");

  // Stalled response beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");

endmodule

bind peer_address_tables pat_chk u_pat_chk (.*);

`default_nettype wire

### sim/tb_peer_address_tables.sv
`timescale 1ns / 1ps

module tb_peer_address_tables;
  import pat_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned PoolSize   = 12;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainWait  = 64;
  localparam longint unsigned CycleLimit = 400000;

  // Receiver stall patterns
  typedef enum int unsigned {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_SPARSE
  } stall_e;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  peer_address_tables #(
    .KNOWN_DEPTH    (Depth),
    .CONNECTED_DEPTH(Depth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Shadow copy of both peer tables
  logic [KeyW-1:0]  known_key [Depth];
  logic [CodeW-1:0] known_st  [Depth];
  int unsigned      known_cnt = 0;
  logic [KeyW-1:0]  conn_key  [Depth];
  int unsigned      conn_cnt  = 0;

  out_t             reply_q[$];
  logic [KeyW-1:0]  key_pool[PoolSize];

  int unsigned errors     = 0;
  int unsigned n_func[4]  = '{default: 0};
  int unsigned n_hits     = 0;
  int unsigned n_refused  = 0;
  int unsigned known_peak = 0;
  int unsigned burst_left = 0;
  bit          hold_req   = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // First known slot holding key, Depth when absent
  function automatic int unsigned first_known(logic [KeyW-1:0] key);
    for (int unsigned i = 0; i < known_cnt; i++) begin
      if (known_key[i] == key) return i;
    end
    return Depth;
  endfunction

  // Expected reply for one request; updates the shadow tables
  function automatic out_t predict_table_reply(in_t req);
    out_t            rsp;
    logic [KeyW-1:0] key;
    int unsigned     hit;
    rsp.found      = 1'b0;
    rsp.slot_index = '0;
    rsp.state_out  = NOT_KNOWN;
    rsp.table_full = 1'b0;
    key = {req.ip_addr, req.port_number};
    n_func[req.func]++;
    case (func_e'(req.func))
      FUNC_FIND_CONN: begin
        for (int unsigned i = 0; i < conn_cnt; i++) begin
          if (conn_key[i] == key) begin
            rsp.found      = 1'b1;
            rsp.slot_index = 4'(i);
            break;
          end
        end
      end
      FUNC_ADD_KNOWN: begin
        if (known_cnt >= Depth) begin
          rsp.table_full = 1'b1;
        end else begin
          known_key[known_cnt] = key;
          known_st[known_cnt]  = req.peer_state;
          rsp.found      = 1'b1;
          rsp.slot_index = 4'(known_cnt);
          known_cnt++;
        end
      end
      FUNC_QUERY_KNOWN: begin
        hit = first_known(key);
        if (hit < Depth) begin
          rsp.found      = 1'b1;
          rsp.slot_index = 4'(hit);
          rsp.state_out  = known_st[hit];
        end
      end
      FUNC_ADD_CONN: begin
        if (conn_cnt >= Depth) begin
          rsp.table_full = 1'b1;
        end else begin
          // drop the first known match and close the gap
          hit = first_known(key);
          if (hit < Depth) begin
            for (int unsigned i = hit; i + 1 < known_cnt; i++) begin
              known_key[i] = known_key[i + 1];
              known_st[i]  = known_st[i + 1];
            end
            known_cnt--;
          end
          conn_key[conn_cnt] = key;
          rsp.found      = 1'b1;
          rsp.slot_index = 4'(conn_cnt);
          conn_cnt++;
        end
      end
      default: ;
    endcase
    if (rsp.table_full) n_refused++;
    if (rsp.found && (req.func == FUNC_FIND_CONN || req.func == FUNC_QUERY_KNOWN)) n_hits++;
    if (known_cnt > known_peak) known_peak = known_cnt;
    return rsp;
  endfunction

  function automatic in_t make_req(func_e op, logic [KeyW-1:0] key, logic [1:0] code);
    in_t req;
    req.func        = op;
    req.ip_addr     = key[47:16];
    req.port_number = key[15:0];
    req.peer_state  = code;
    return req;
  endfunction

  function automatic logic [KeyW-1:0] pool_or_fresh();
    logic [63:0] w;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, PoolSize - 1)];
    return w[KeyW-1:0];
  endfunction

  // Mostly keys already held in a table so lookups hit
  function automatic logic [KeyW-1:0] lookup_key(bit from_known);
    int unsigned cnt;
    cnt = from_known ? known_cnt : conn_cnt;
    if (cnt != 0 && $urandom_range(0, 99) < 65) begin
      if (from_known) return known_key[$urandom_range(0, cnt - 1)];
      return conn_key[$urandom_range(0, cnt - 1)];
    end
    return pool_or_fresh();
  endfunction

  function automatic in_t random_req();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 34) return make_req(FUNC_FIND_CONN, lookup_key(1'b0), 2'($urandom_range(0, 3)));
    if (pick < 82) return make_req(FUNC_QUERY_KNOWN, lookup_key(1'b1), 2'($urandom_range(0, 3)));
    if (pick < 96) return make_req(FUNC_ADD_KNOWN, pool_or_fresh(), 2'($urandom_range(0, 3)));
    return make_req(FUNC_ADD_CONN, lookup_key(1'b1), 2'($urandom_range(0, 3)));
  endfunction

  // Send one request beat; bursts with random gaps in between
  task automatic send_req(in_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    reply_q.push_back(predict_table_reply(req));
  endtask

  // Lookups against empty tables
  task automatic test_empty_tables();
    send_req(make_req(FUNC_FIND_CONN, key_pool[0], 2'd0));
    send_req(make_req(FUNC_QUERY_KNOWN, key_pool[1], 2'd3));
  endtask

  // Appends with extreme keys, every code, duplicates, first-match queries
  task automatic test_known_appends();
    send_req(make_req(FUNC_ADD_KNOWN, key_pool[0], 2'd0));
    send_req(make_req(FUNC_ADD_KNOWN, key_pool[1], 2'd3));
    send_req(make_req(FUNC_ADD_KNOWN, key_pool[2], 2'd1));
    send_req(make_req(FUNC_ADD_KNOWN, key_pool[2], 2'd2));
    send_req(make_req(FUNC_ADD_KNOWN, key_pool[3], 2'd2));
    send_req(make_req(FUNC_QUERY_KNOWN, key_pool[1], 2'd0));
    send_req(make_req(FUNC_QUERY_KNOWN, key_pool[2], 2'd1));
    send_req(make_req(FUNC_QUERY_KNOWN, key_pool[4], 2'd2));
  endtask

  // Connecting a peer removes its first known entry and shifts the rest
  task automatic test_connect_moves();
    send_req(make_req(FUNC_ADD_CONN, key_pool[2], 2'd0));
    send_req(make_req(FUNC_QUERY_KNOWN, key_pool[2], 2'd0));
    send_req(make_req(FUNC_QUERY_KNOWN, key_pool[3], 2'd1));
    send_req(make_req(FUNC_ADD_CONN, key_pool[5], 2'd2));
    send_req(make_req(FUNC_ADD_CONN, key_pool[1], 2'd3));
    send_req(make_req(FUNC_FIND_CONN, key_pool[5], 2'd0));
    send_req(make_req(FUNC_FIND_CONN, key_pool[2], 2'd1));
    send_req(make_req(FUNC_FIND_CONN, key_pool[4], 2'd2));
    send_req(make_req(FUNC_QUERY_KNOWN, key_pool[3], 2'd3));
  endtask

  task automatic test_random_traffic(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      send_req(random_req());
    end
  endtask

  // Receiver holds off while requests keep coming back to back
  task automatic test_output_hold_off();
    hold_req   = 1'b1;
    burst_left = 1000;
    for (int unsigned k = 0; k < 12; k++) begin
      send_req(random_req());
    end
    burst_left = 0;
  endtask

  // Receiver ready pattern, switched between randomly chosen modes
  initial begin : out_ready_gen
    stall_e      mode;
    int unsigned left;
    int unsigned tick;
    mode = READY_ALWAYS;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = stall_e'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        tick++;
        case (mode)
          READY_ALWAYS:   out_ready_i <= 1'b1;
          READY_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
          READY_PERIODIC: out_ready_i <= (tick % 5) < 2;
          default:        out_ready_i <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // Compare each reply beat with the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        $error("reply beat with no request pending: %p", out_data_o);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (out_data_o.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_data_o.found);
          errors++;
        end
        if (out_data_o.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, out_data_o.slot_index);
          errors++;
        end
        if (out_data_o.state_out !== want.state_out) begin
          $error("state_out: expected %0d, got %0d", want.state_out, out_data_o.state_out);
          errors++;
        end
        if (out_data_o.table_full !== want.table_full) begin
          $error("table_full: expected %0b, got %0b", want.table_full, out_data_o.table_full);
          errors++;
        end
      end
    end
  end

  // Run limit
  initial begin : watchdog
    longint unsigned cycles;
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] w;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int unsigned i = 2; i < PoolSize; i++) begin
      w = {$urandom, $urandom};
      key_pool[i] = w[KeyW-1:0];
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_tables();
    test_known_appends();
    test_connect_moves();
    test_random_traffic(360);
    test_output_hold_off();
    test_random_traffic(360);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Covered %0d find-connected, %0d add-known, %0d query-known, %0d add-connected.",
             n_func[FUNC_FIND_CONN], n_func[FUNC_ADD_KNOWN], n_func[FUNC_QUERY_KNOWN],
             n_func[FUNC_ADD_CONN]);
    $display("%0d lookup hits, %0d refused appends; known peak %0d, connected %0d entries.",
             n_hits, n_refused, known_peak, conn_cnt);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
